// ----- design/bdlp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types, item codes and register map of the button debouncer.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	// default number of buttons
	localparam int BDLP_BUTTON_COUNT = 4;

	// widths fixed by the item fields
	localparam int KIND_W    = 2;
	localparam int TIME_W    = 32;
	localparam int RAW_W     = 4;
	localparam int INDEX_W   = 8;
	localparam int PENDING_W = 4;
	localparam int CFG_W     = 16;

	// apb port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_TIME = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_SAMPLE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TAKE_PRESS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TAKE_LONG  = 2'd2;

	// configuration seen by the button cells
	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] long_press_time;
	} cfg_t;

	// per-item control broadcast to every cell
	typedef struct packed {
		logic              advance;
		logic              sample;
		logic [TIME_W-1:0] now_ms;
	} cell_ctl_t;

	// consume request for one cell
	typedef struct packed {
		logic press_take;
		logic long_take;
	} cell_take_t;

	// flags and consume outcome of one cell
	typedef struct packed {
		logic press_q;
		logic press_next;
		logic long_q;
		logic long_next;
		logic hit;
	} cell_stat_t;

endpackage

// ----- design/bdlp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp request and response channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bdlp_req_if;
	logic                             valid;
	logic                             ready;
	logic [bdlp_pkg::KIND_W-1:0]      kind;
	logic [bdlp_pkg::TIME_W-1:0]      now_ms;
	logic [bdlp_pkg::RAW_W-1:0]       raw_levels;
	logic [bdlp_pkg::INDEX_W-1:0]     button_index;

	modport source (output valid, kind, now_ms, raw_levels, button_index, input ready);
	modport sink   (input valid, kind, now_ms, raw_levels, button_index, output ready);
endinterface

interface bdlp_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             consumed;
	logic [bdlp_pkg::PENDING_W-1:0]   press_pending;
	logic [bdlp_pkg::PENDING_W-1:0]   long_pending;

	modport source (output valid, consumed, press_pending, long_pending, input ready);
	modport sink   (input valid, consumed, press_pending, long_pending, output ready);
endinterface

// ----- design/button_debounce_long_press.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces active-low buttons and keeps sticky press and long-press flags.
// ----------------------------------------------------------------------------
// path: an accepted beat moves from the input register to the result register, which offers it
// throughput: one beat per cycle unless a waiting result stalls; input register, one cell update, result register
// a waiting result holds off the input only once the input register is also full
// reset: buttons released, stamps and flags zero, debounce 50 ms, long press 1000 ms
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
	parameter int BUTTON_COUNT = bdlp_pkg::BDLP_BUTTON_COUNT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bdlp_req_if.sink                            req,
	bdlp_rsp_if.source                          rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bdlp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bdlp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bdlp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	bdlp_pkg::cfg_t                   cfg;
	bdlp_pkg::cell_ctl_t              ctl;
	bdlp_pkg::cell_take_t             take   [BUTTON_COUNT];
	bdlp_pkg::cell_stat_t             stat   [BUTTON_COUNT];

	logic                             valid_s1;
	logic [bdlp_pkg::KIND_W-1:0]      kind_s1;
	logic [bdlp_pkg::TIME_W-1:0]      now_s1;
	logic [bdlp_pkg::RAW_W-1:0]       raw_s1;
	logic [bdlp_pkg::INDEX_W-1:0]     index_s1;

	logic                             out_valid_q;
	logic                             consumed_q;
	logic [bdlp_pkg::PENDING_W-1:0]   press_pend_q;
	logic [bdlp_pkg::PENDING_W-1:0]   long_pend_q;

	logic                             adv;
	logic [BUTTON_COUNT-1:0]          hit_vec;
	logic [BUTTON_COUNT-1:0]          press_cur;
	logic [BUTTON_COUNT-1:0]          press_nxt;
	logic [bdlp_pkg::PENDING_W-1:0]   press_pend;
	logic [bdlp_pkg::PENDING_W-1:0]   long_pend;

	// configuration registers
	bdlp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: s1 moves on when the result register is free or being drained
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1  <= req.kind;
			now_s1   <= req.now_ms;
			raw_s1   <= req.raw_levels;
			index_s1 <= req.button_index;
		end
	end

	// broadcast control
	assign ctl.advance = adv;
	assign ctl.sample  = (kind_s1 == bdlp_pkg::KIND_SAMPLE);
	assign ctl.now_ms  = now_s1;

	// button cells
	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_cell
		logic level;
		logic sel;

		if (i < bdlp_pkg::RAW_W) begin : g_raw
			assign level = raw_s1[i];
		end else begin : g_noraw
			assign level = 1'b0;
		end

		assign sel = (index_s1 == bdlp_pkg::INDEX_W'(i));
		assign take[i].press_take = sel && (kind_s1 == bdlp_pkg::KIND_TAKE_PRESS);
		assign take[i].long_take  = sel && (kind_s1 == bdlp_pkg::KIND_TAKE_LONG);

		bdlp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg),
			.ctl    (ctl),
			.take   (take[i]),
			.level  (level),
			.stat   (stat[i])
		);

		assign hit_vec[i]   = stat[i].hit;
		assign press_cur[i] = stat[i].press_q;
		assign press_nxt[i] = stat[i].press_next;
	end

	// visible flags: low buttons only
	for (genvar j = 0; j < bdlp_pkg::PENDING_W; j++) begin : g_pend
		if (j < BUTTON_COUNT) begin : g_on
			assign press_pend[j] = stat[j].press_next;
			assign long_pend[j]  = stat[j].long_next;
		end else begin : g_off
			assign press_pend[j] = 1'b0;
			assign long_pend[j]  = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			consumed_q   <= |hit_vec;
			press_pend_q <= press_pend;
			long_pend_q  <= long_pend;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.consumed      = consumed_q;
	assign rsp.press_pending = press_pend_q;
	assign rsp.long_pending  = long_pend_q;

	// a consume beat clears at most one flag
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> $onehot0(hit_vec))
		else $error("more than one button consumed by one beat");

	// a sample beat never reports a consume
	a_sample_no_consume: assert property (@(posedge clk) disable iff (!arst_n)
		adv && kind_s1 == bdlp_pkg::KIND_SAMPLE |=> !consumed_q)
		else $error("sample beat reported a consume");

	// a consume beat never raises a press flag
	a_take_no_press: assert property (@(posedge clk) disable iff (!arst_n)
		adv && kind_s1 != bdlp_pkg::KIND_SAMPLE |-> (press_nxt & ~press_cur) == '0)
		else $error("consume beat set a press flag");

	// a new result only follows a beat in the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared with no beat in the input register");

endmodule

// ----- design/bdlp_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_regs
// APB register file holding the debounce and long-press times.
// ----------------------------------------------------------------------------
module bdlp_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bdlp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bdlp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bdlp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output bdlp_pkg::cfg_t                      cfg
);

	logic [bdlp_pkg::CFG_W-1:0]     debounce_q;
	logic [bdlp_pkg::CFG_W-1:0]     long_press_q;
	logic [bdlp_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[bdlp_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bdlp_pkg::DEBOUNCE_RESET;
			long_press_q <= bdlp_pkg::LONG_PRESS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				bdlp_pkg::REG_DEBOUNCE_TIME:   debounce_q   <= pwdata[bdlp_pkg::CFG_W-1:0];
				bdlp_pkg::REG_LONG_PRESS_TIME: long_press_q <= pwdata[bdlp_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			bdlp_pkg::REG_DEBOUNCE_TIME:   prdata = bdlp_pkg::APB_DATA_W'(debounce_q);
			bdlp_pkg::REG_LONG_PRESS_TIME: prdata = bdlp_pkg::APB_DATA_W'(long_press_q);
			default:                       prdata = '0;
		endcase
	end

	assign cfg.debounce_time   = debounce_q;
	assign cfg.long_press_time = long_press_q;

endmodule

// ----- design/bdlp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_cell
// Debounce state, press/long-press flags and time stamps of one button.
// ----------------------------------------------------------------------------
module bdlp_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bdlp_pkg::cfg_t         cfg,
	input  bdlp_pkg::cell_ctl_t    ctl,
	input  bdlp_pkg::cell_take_t   take,
	input  logic                   level,
	output bdlp_pkg::cell_stat_t   stat
);

	logic                        prev_q;
	logic                        stable_q;
	logic [bdlp_pkg::TIME_W-1:0] change_q;
	logic [bdlp_pkg::TIME_W-1:0] press_stamp_q;
	logic                        press_q;
	logic                        long_q;

	logic [bdlp_pkg::TIME_W-1:0] stamp;
	logic                        settled;
	logic                        held_long;
	logic                        stable_next;
	logic                        press_next;
	logic                        long_next;
	logic                        restamp_press;
	logic                        hit;

	// elapsed times, wrapping
	assign stamp     = (level != prev_q) ? ctl.now_ms : change_q;
	assign settled   = (ctl.now_ms - stamp) > bdlp_pkg::TIME_W'(cfg.debounce_time);
	assign held_long = (ctl.now_ms - press_stamp_q) >= bdlp_pkg::TIME_W'(cfg.long_press_time);

	// next flags for a sample or a consume beat
	always_comb begin
		stable_next   = stable_q;
		press_next    = press_q;
		long_next     = long_q;
		restamp_press = 1'b0;
		hit           = 1'b0;
		if (ctl.sample) begin
			if (settled) begin
				if (level != stable_q) begin
					stable_next = level;
					if (!level) begin
						press_next    = 1'b1;
						long_next     = 1'b0;
						restamp_press = 1'b1;
					end else if (held_long) begin
						long_next = 1'b1;
					end
				end else if (!level && !long_q && held_long) begin
					long_next = 1'b1;
				end
			end
		end else if (take.press_take) begin
			hit        = press_q;
			press_next = 1'b0;
		end else if (take.long_take) begin
			hit       = long_q;
			long_next = 1'b0;
		end
	end

	// state update on an advancing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= 1'b1;
			stable_q      <= 1'b1;
			change_q      <= '0;
			press_stamp_q <= '0;
			press_q       <= 1'b0;
			long_q        <= 1'b0;
		end else if (ctl.advance) begin
			stable_q <= stable_next;
			press_q  <= press_next;
			long_q   <= long_next;
			if (ctl.sample) begin
				prev_q   <= level;
				change_q <= stamp;
			end
			if (restamp_press) begin
				press_stamp_q <= ctl.now_ms;
			end
		end
	end

	assign stat.press_q    = press_q;
	assign stat.press_next = press_next;
	assign stat.long_q     = long_q;
	assign stat.long_next  = long_next;
	assign stat.hit        = hit;

endmodule
